// ----- rtl/core/poa_pkg.sv -----
// Shared types and constants for the paged object pool allocator.
package poa_pkg;

   // Fixed widths of the transfer fields and of the layout arithmetic.
   localparam int OFFSET_W      = 17;
   localparam int PAGE_FIELD_W  = 6;
   localparam int COUNT_FIELD_W = 13;
   localparam int SIZE_W        = 11;
   localparam int PITCH_W       = 12;
   localparam int FIRST_W       = 8;
   localparam int CFG_W         = 11;
   localparam int CFG_INDEX_W   = 3;

   // Operation code carried in the request sideband.
   localparam logic OP_FREE = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [CFG_INDEX_W-1:0] CFG_OBJECT_SIZE      = 3'd0;
   localparam logic [CFG_INDEX_W-1:0] CFG_OBJECTS_PER_PAGE = 3'd1;
   localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAGES        = 3'd2;
   localparam logic [CFG_INDEX_W-1:0] CFG_PAD_BYTES        = 3'd3;
   localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_BYTES     = 3'd4;
   localparam logic [CFG_INDEX_W-1:0] CFG_ALIGN_BYTES      = 3'd5;
   localparam logic [CFG_INDEX_W-1:0] CFG_CHECKS_ENABLE    = 3'd6;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_NO_PAGES      = 3'd1,
      ST_MULTIPLE_FREE = 3'd2,
      ST_BAD_ADDRESS   = 3'd3,
      ST_BAD_BOUNDARY  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_LAYOUT,
      S_POP,
      S_GRANT,
      S_OFFSET,
      S_CHECK,
      S_DIVIDE,
      S_VERIFY,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [SIZE_W-1:0] object_size;
      logic [6:0]        objects_per_page;
      logic [6:0]        max_pages;
      logic [4:0]        pad_bytes;
      logic [4:0]        header_bytes;
      logic [4:0]        align_bytes;
      logic              checks_enable;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       latch_req;
      logic       mul_pages;
      logic       lay_start;
      logic       lay_step;
      logic       pop;
      logic       grant;
      logic       offset_sum;
      logic       div_start;
      logic       free_commit;
      logic       set_status;
      status_type status_code;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_free;
      logic stack_empty;
      logic pages_full;
      logic lay_last;
      logic addr_bad;
      logic before_first;
      logic div_busy;
      logic rem_nonzero;
      logic slot_over;
      logic map_bit;
   } stat_type;

endpackage

// ----- rtl/core/poa_div.sv -----
// Restoring divider that splits a block offset into slot index and remainder.
module poa_div
   import poa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [OFFSET_W-1:0] dividend,
   input  logic [PITCH_W-1:0]  divisor,
   output logic                busy,
   output logic [OFFSET_W-1:0] quotient,
   output logic [PITCH_W-1:0]  remainder
);

   localparam int STEP_W = $clog2(OFFSET_W + 1);

   logic [STEP_W-1:0]   step_ff, step_in;
   logic [OFFSET_W-1:0] quo_ff, quo_in;
   logic [PITCH_W-1:0]  rem_ff, rem_in;
   logic [PITCH_W-1:0]  divisor_ff, divisor_in;
   logic [PITCH_W:0]    trial;
   logic                fits;

   // One quotient bit per cycle, most significant first.
   always_comb begin
      trial      = {rem_ff, quo_ff[OFFSET_W-1]};
      fits       = trial >= {1'b0, divisor_ff};
      step_in    = step_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         step_in    = STEP_W'(OFFSET_W);
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (step_ff != '0) begin
         step_in = step_ff - 1'b1;
         quo_in  = {quo_ff[OFFSET_W-2:0], fits};
         rem_in  = fits ? PITCH_W'(trial - {1'b0, divisor_ff}) : PITCH_W'(trial);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign busy      = step_ff != '0;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/core/poa_dp.sv -----
// Datapath of the pool: free stack, in-use map, counters and layout arithmetic.
module poa_dp
   import poa_pkg::*;
#(
   parameter int PAGES_MAX     = 64,
   parameter int SLOTS_MAX     = 64,
   parameter int POINTER_BYTES = 8
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic                     req_op,
   input  logic [PAGE_FIELD_W-1:0]  req_page,
   input  logic [OFFSET_W-1:0]      req_offset,
   output status_type               res_status,
   output logic [PAGE_FIELD_W-1:0]  res_page,
   output logic [OFFSET_W-1:0]      res_offset,
   output logic [COUNT_FIELD_W-1:0] res_in_use,
   output logic [COUNT_FIELD_W-1:0] res_free,
   output logic [COUNT_FIELD_W-1:0] res_peak
);

   localparam int DEPTH = PAGES_MAX * SLOTS_MAX;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = (PAGES_MAX > 1) ? $clog2(PAGES_MAX) : 1;
   localparam int SW    = (SLOTS_MAX > 1) ? $clog2(SLOTS_MAX) : 1;
   localparam int EW    = PW + SW;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int PCW   = $clog2(PAGES_MAX + 1);
   localparam int NW    = $clog2(SLOTS_MAX + 1);
   localparam int PRW   = NW + PITCH_W;
   localparam int PSW   = PRW + 1;

   // Flat map address of a page and slot.
   function automatic logic [AW-1:0] flat_addr(input logic [PW-1:0] pg,
                                                input logic [SW-1:0] sl);
      flat_addr = AW'(int'(pg) * SLOTS_MAX + int'(sl));
   endfunction

   // Stores: stack entries are {page, slot}; the map holds one in-use bit per object.
   logic [EW-1:0] free_stack_ff [DEPTH];
   logic          in_use_map_ff [DEPTH];
   logic [EW-1:0] entry_rd_ff;
   logic          map_rd_ff;

   logic                    req_op_ff, req_op_in;
   logic [PAGE_FIELD_W-1:0] req_page_ff, req_page_in;
   logic [OFFSET_W-1:0]     req_offset_ff, req_offset_in;
   status_type              status_ff, status_in;
   logic [PW-1:0]           gpage_ff, gpage_in;
   logic [OFFSET_W-1:0]     goff_ff, goff_in;
   logic [PRW-1:0]          product_ff, product_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [PCW-1:0]          pages_ff, pages_in;
   logic [CW-1:0]           out_ff, out_in;
   logic [CW-1:0]           peak_ff, peak_in;
   logic [SW-1:0]           lay_ff, lay_in;

   logic [SIZE_W-1:0]   eff_size;
   logic [NW-1:0]       eff_slots;
   logic [PCW-1:0]      eff_pages;
   logic [PITCH_W-1:0]  pitch;
   logic [FIRST_W-1:0]  first;
   logic [PSW-1:0]      page_size;
   logic [PSW-1:0]      offset_sum;
   logic [OFFSET_W-1:0] dividend;
   logic [OFFSET_W-1:0] div_quo;
   logic [PITCH_W-1:0]  div_rem;
   logic                div_busy;
   logic [PW-1:0]       entry_page;
   logic [SW-1:0]       entry_slot;
   logic [PW-1:0]       free_pg;
   logic [SW-1:0]       free_sl;
   logic                stack_full;
   logic                lay_push;
   logic                lay_last;

   logic                map_we;
   logic [AW-1:0]       map_wa;
   logic                map_wd;
   logic                stack_we;
   logic [AW-1:0]       stack_wa;
   logic [EW-1:0]       stack_wd;

   // Effective layout values from the current registers.
   always_comb begin
      eff_size = (cfg.object_size < SIZE_W'(POINTER_BYTES)) ? SIZE_W'(POINTER_BYTES)
                                                            : cfg.object_size;
      if (cfg.objects_per_page == '0) begin
         eff_slots = NW'(1);
      end else if (cfg.objects_per_page > SLOTS_MAX) begin
         eff_slots = NW'(SLOTS_MAX);
      end else begin
         eff_slots = NW'(cfg.objects_per_page);
      end
      eff_pages = (cfg.max_pages > PAGES_MAX) ? PCW'(PAGES_MAX) : PCW'(cfg.max_pages);
      pitch = PITCH_W'(eff_size) + PITCH_W'({cfg.pad_bytes, 1'b0})
            + PITCH_W'(cfg.header_bytes) + PITCH_W'(cfg.align_bytes);
      first = FIRST_W'(POINTER_BYTES) + FIRST_W'(cfg.align_bytes)
            + FIRST_W'(cfg.header_bytes) + FIRST_W'(cfg.pad_bytes);
   end

   assign entry_page = entry_rd_ff[EW-1:SW];
   assign entry_slot = entry_rd_ff[SW-1:0];
   assign free_pg    = PW'(req_page_ff);
   assign free_sl    = SW'(div_quo);
   assign page_size  = PSW'(POINTER_BYTES) + PSW'(product_ff);
   assign offset_sum = PSW'(first) + PSW'(product_ff);
   assign dividend   = req_offset_ff - OFFSET_W'(first);
   assign stack_full = count_ff == CW'(DEPTH);
   assign lay_push   = lay_ff < eff_slots;
   assign lay_last   = lay_ff == SW'(SLOTS_MAX - 1);

   poa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dividend),
      .divisor   (pitch),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Status back to the controller.
   always_comb begin
      stat.is_free      = req_op_ff == OP_FREE;
      stat.stack_empty  = count_ff == '0;
      stat.pages_full   = pages_ff >= eff_pages;
      stat.lay_last     = lay_last;
      stat.addr_bad     = (req_page_ff >= pages_ff) || (req_page_ff >= PAGES_MAX)
                       || (req_offset_ff == '0) || (req_offset_ff >= page_size);
      stat.before_first = req_offset_ff < first;
      stat.div_busy     = div_busy;
      stat.rem_nonzero  = div_rem != '0;
      stat.slot_over    = div_quo >= SLOTS_MAX;
      stat.map_bit      = map_rd_ff;
   end

   // Write ports of the two stores.
   always_comb begin
      map_we   = 1'b0;
      map_wa   = flat_addr(free_pg, free_sl);
      map_wd   = 1'b0;
      if (cmd.lay_step) begin
         map_we = 1'b1;
         map_wa = flat_addr(PW'(pages_ff), lay_ff);
      end else if (cmd.grant) begin
         map_we = 1'b1;
         map_wa = flat_addr(entry_page, entry_slot);
         map_wd = 1'b1;
      end else if (cmd.free_commit) begin
         map_we = 1'b1;
      end

      stack_we = 1'b0;
      stack_wa = AW'(count_ff);
      stack_wd = {free_pg, free_sl};
      if (cmd.lay_step && lay_push && !stack_full) begin
         stack_we = 1'b1;
         stack_wd = {PW'(pages_ff), lay_ff};
      end else if (cmd.free_commit && !stack_full) begin
         stack_we = 1'b1;
      end
   end

   // Next values of the request, result and counter registers.
   always_comb begin
      req_op_in     = req_op_ff;
      req_page_in   = req_page_ff;
      req_offset_in = req_offset_ff;
      status_in     = status_ff;
      gpage_in      = gpage_ff;
      goff_in       = goff_ff;
      product_in    = product_ff;
      count_in      = count_ff;
      pages_in      = pages_ff;
      out_in        = out_ff;
      peak_in       = peak_ff;
      lay_in        = lay_ff;

      if (cmd.latch_req) begin
         req_op_in     = req_op;
         req_page_in   = req_page;
         req_offset_in = req_offset;
         status_in     = ST_OK;
         gpage_in      = '0;
         goff_in       = '0;
      end

      // No_pages is always reported; free errors only with checks on.
      if (cmd.set_status) begin
         status_in = (cmd.status_code == ST_NO_PAGES || cfg.checks_enable)
                   ? cmd.status_code : ST_OK;
      end

      if (cmd.mul_pages) begin
         product_in = PRW'(PRW'(eff_slots) * PRW'(pitch));
      end

      // Page layout sweeps every slot, clearing its map bit and pushing the used ones.
      if (cmd.lay_start) begin
         lay_in = '0;
      end
      if (cmd.lay_step) begin
         lay_in = lay_ff + 1'b1;
         if (lay_push && !stack_full) begin
            count_in = count_ff + 1'b1;
         end
         if (lay_last) begin
            pages_in = pages_ff + 1'b1;
         end
      end

      if (cmd.pop) begin
         count_in = count_ff - 1'b1;
      end

      if (cmd.grant) begin
         gpage_in   = entry_page;
         product_in = PRW'(PRW'(entry_slot) * PRW'(pitch));
         out_in     = out_ff + 1'b1;
         if (out_ff + 1'b1 > peak_ff) begin
            peak_in = out_ff + 1'b1;
         end
      end

      if (cmd.offset_sum) begin
         goff_in = OFFSET_W'(offset_sum);
      end

      if (cmd.free_commit) begin
         if (!stack_full) begin
            count_in = count_ff + 1'b1;
         end
         if (out_ff != '0) begin
            out_in = out_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pages_ff <= '0;
         out_ff   <= '0;
         peak_ff  <= '0;
         lay_ff   <= '0;
      end else begin
         count_ff <= count_in;
         pages_ff <= pages_in;
         out_ff   <= out_in;
         peak_ff  <= peak_in;
         lay_ff   <= lay_in;
      end
   end

   always_ff @(posedge clock) begin
      req_op_ff     <= req_op_in;
      req_page_ff   <= req_page_in;
      req_offset_ff <= req_offset_in;
      status_ff     <= status_in;
      gpage_ff      <= gpage_in;
      goff_ff       <= goff_in;
      product_ff    <= product_in;
   end

   // Free stack: the top entry is read every cycle.
   always_ff @(posedge clock) begin
      if (stack_we) begin
         free_stack_ff[stack_wa] <= stack_wd;
      end
      entry_rd_ff <= free_stack_ff[AW'(count_ff - 1'b1)];
   end

   // In-use map: read at the slot the divider has found.
   always_ff @(posedge clock) begin
      if (map_we) begin
         in_use_map_ff[map_wa] <= map_wd;
      end
      map_rd_ff <= in_use_map_ff[flat_addr(free_pg, free_sl)];
   end

   assign res_status = status_ff;
   assign res_page   = PAGE_FIELD_W'(gpage_ff);
   assign res_offset = goff_ff;
   assign res_in_use = COUNT_FIELD_W'(out_ff);
   assign res_free   = COUNT_FIELD_W'(count_ff);
   assign res_peak   = COUNT_FIELD_W'(peak_ff);

endmodule

// ----- rtl/core/poa_ctrl.sv -----
// Controller state machine that sequences allocate and free requests.
module poa_ctrl
   import poa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  logic     rsp_free,
   output logic     rsp_load,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_free) begin
               cmd.mul_pages = 1'b1;
               state_in      = S_CHECK;
            end else if (!stat.stack_empty) begin
               state_in = S_POP;
            end else if (stat.pages_full) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_NO_PAGES;
               state_in        = S_FINISH;
            end else begin
               cmd.lay_start = 1'b1;
               state_in      = S_LAYOUT;
            end
         end
         S_LAYOUT: begin
            cmd.lay_step = 1'b1;
            if (stat.lay_last) begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = S_GRANT;
         end
         S_GRANT: begin
            cmd.grant = 1'b1;
            state_in  = S_OFFSET;
         end
         S_OFFSET: begin
            cmd.offset_sum = 1'b1;
            state_in       = S_FINISH;
         end
         S_CHECK: begin
            priority if (stat.addr_bad) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_BAD_ADDRESS;
               state_in        = S_FINISH;
            end else if (stat.before_first) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_BAD_BOUNDARY;
               state_in        = S_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (!stat.div_busy) begin
               priority if (stat.rem_nonzero) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_BAD_BOUNDARY;
                  state_in        = S_FINISH;
               end else if (stat.slot_over) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_MULTIPLE_FREE;
                  state_in        = S_FINISH;
               end else begin
                  state_in = S_VERIFY;
               end
            end
         end
         S_VERIFY: begin
            if (stat.map_bit) begin
               cmd.free_commit = 1'b1;
            end else begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_MULTIPLE_FREE;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/paged_object_pool_allocator.sv -----
// Top level of the paged object pool allocator: registers, result stage and wiring.
// The pool handles one request at a time and takes the next request as soon as the
// previous result has moved into the output register, even while that result is still
// waiting to be taken. An allocate from a non-empty free stack pops an entry directly;
// one that must lay out a new page first runs the layout sweep, which clears one in-use
// bit per cycle over every slot of the page and pushes a free-stack entry for each slot
// within the configured objects per page. A free that passes the address checks goes
// through the 17-step offset divider that finds the slot and checks the block pitch; a
// free rejected for a bad address or an offset before the first block skips the
// divider. There is no clearing pass after reset: each page's in-use bits are cleared
// while it is laid out.
module paged_object_pool_allocator
   import poa_pkg::*;
#(
   parameter int PAGES_MAX     = 64,
   parameter int SLOTS_MAX     = 64,
   parameter int POINTER_BYTES = 8
)
(
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: free_page [5:0], free_offset [22:6], zero [23]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [23:0]            req_tdata,
   // req_tuser: operation [0]
   input  logic [0:0]             req_tuser,
   // rsp_tdata: granted_page [5:0], granted_offset [22:6], objects_in_use [35:23],
   //            free_objects [48:36], most_in_use [61:49], zero [63:62]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata,
   // rsp_tuser: status [2:0]
   output logic [2:0]             rsp_tuser,
   input  logic                   csr_wr_en,
   input  logic [CFG_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   cmd_type  cmd;
   stat_type stat;
   logic     rsp_load;
   logic     rsp_free;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [PAGE_FIELD_W-1:0]  rsp_page_ff, rsp_page_in;
   logic [OFFSET_W-1:0]      rsp_offset_ff, rsp_offset_in;
   logic [COUNT_FIELD_W-1:0] rsp_in_use_ff, rsp_in_use_in;
   logic [COUNT_FIELD_W-1:0] rsp_free_ff, rsp_free_in;
   logic [COUNT_FIELD_W-1:0] rsp_peak_ff, rsp_peak_in;

   status_type               res_status;
   logic [PAGE_FIELD_W-1:0]  res_page;
   logic [OFFSET_W-1:0]      res_offset;
   logic [COUNT_FIELD_W-1:0] res_in_use;
   logic [COUNT_FIELD_W-1:0] res_free;
   logic [COUNT_FIELD_W-1:0] res_peak;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CFG_OBJECT_SIZE:      cfg_in.object_size      = csr_wdata;
            CFG_OBJECTS_PER_PAGE: cfg_in.objects_per_page = csr_wdata[6:0];
            CFG_MAX_PAGES:        cfg_in.max_pages        = csr_wdata[6:0];
            CFG_PAD_BYTES:        cfg_in.pad_bytes        = csr_wdata[4:0];
            CFG_HEADER_BYTES:     cfg_in.header_bytes     = csr_wdata[4:0];
            CFG_ALIGN_BYTES:      cfg_in.align_bytes      = csr_wdata[4:0];
            CFG_CHECKS_ENABLE:    cfg_in.checks_enable    = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.object_size      <= SIZE_W'(16);
         cfg_ff.objects_per_page <= 7'd4;
         cfg_ff.max_pages        <= 7'd2;
         cfg_ff.pad_bytes        <= '0;
         cfg_ff.header_bytes     <= '0;
         cfg_ff.align_bytes      <= '0;
         cfg_ff.checks_enable    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   poa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_free   (rsp_free),
      .rsp_load   (rsp_load),
      .stat       (stat),
      .cmd        (cmd)
   );

   poa_dp #(
      .PAGES_MAX     (PAGES_MAX),
      .SLOTS_MAX     (SLOTS_MAX),
      .POINTER_BYTES (POINTER_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .stat       (stat),
      .req_op     (req_tuser[0]),
      .req_page   (req_tdata[5:0]),
      .req_offset (req_tdata[22:6]),
      .res_status (res_status),
      .res_page   (res_page),
      .res_offset (res_offset),
      .res_in_use (res_in_use),
      .res_free   (res_free),
      .res_peak   (res_peak)
   );

   // Output register: a finished result waits here until its transfer.
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_in_use_in = rsp_in_use_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_peak_in   = rsp_peak_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status;
         rsp_page_in   = res_page;
         rsp_offset_in = res_offset;
         rsp_in_use_in = res_in_use;
         rsp_free_in   = res_free;
         rsp_peak_in   = res_peak;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_in_use_ff <= rsp_in_use_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_peak_ff   <= rsp_peak_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_peak_ff, rsp_free_ff, rsp_in_use_ff,
                        rsp_offset_ff, rsp_page_ff};

endmodule
